// ----- sv/barometric_pressure_compensation_core_defines.svh -----
// Assertion helpers for the pressure compensation core.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_DEFINES_SVH

// Clocked check, muted while reset is held.
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/bpc_pkg.sv -----
package bpc_pkg;

  localparam int RawW   = 20;
  localparam int CfgIdxW = 3;
  localparam int CfgW   = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegT1   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegT2T3 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegP1P2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegP3P4 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegP5P6 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegP7P8 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegP9   = 3'd6;

  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] PresFull   = 64'd1048576;
  localparam logic [63:0] PresScale  = 64'd3125;
  localparam logic [31:0] TempRound  = 32'd128;
  localparam logic [63:0] P1Bias     = 64'd1 << 47;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
    return 64'($signed(x) >>> n);
  endfunction

  // low 64 bits of a 64-bit word times a 17-bit signed coefficient
  function automatic logic [63:0] mulc(input logic [63:0] x, input logic signed [16:0] c);
    logic signed [80:0] pr;
    pr = $signed(x) * c;
    return pr[63:0];
  endfunction

  function automatic logic signed [16:0] sx17(input logic [15:0] h);
    return {h[15], h};
  endfunction

endpackage

// ----- sv/bpc_if.sv -----
interface bpc_in_if import bpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_temperature;
  logic [RawW-1:0] raw_pressure;
  modport source(output valid, raw_temperature, raw_pressure, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic        pressure_invalid;
  modport source(output valid, temperature_centi, pressure_q24_8, pressure_invalid,
                 input ready);
  modport sink(input valid, temperature_centi, pressure_q24_8, pressure_invalid,
               output ready);
endinterface

interface bpc_cfg_if import bpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/barometric_pressure_compensation_core.sv -----
// Barometric pressure compensation core, 64-bit integer scheme.
// Channels: in_ch takes one beat of raw 20-bit temperature and pressure;
// out_ch returns one beat per input with temperature in 0.01 degree steps,
// pressure in Pa as unsigned Q24.8 and a flag that marks a zero divisor
// (pressure then reads 0). cfg_ch writes the seven calibration registers by
// index; unknown indexes are dropped. cfg_ch is always ready; write it only
// while the pipeline is empty.
// Throughput: one beat per cycle while out_ch is not stalled. Every stage is a register slice; the
// signed 64-bit division is a 64-stage restoring array, one quotient bit per
// stage, so a new beat enters each cycle.
// Pipeline: 11 front stages, 64 divider stages, 5 back stages, the last one
// being the output register.
// Stall: when out_ch is valid and not taken, the whole pipe holds and in_ch
// drops ready; nothing is lost or repeated. Stall-free the pipe moves every
// cycle.
// Reset (rst_n low, synchronous): clears all stage valid bits and the
// calibration registers to zero.
`include "barometric_pressure_compensation_core_defines.svh"

module barometric_pressure_compensation_core import bpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch,
  bpc_cfg_if.sink   cfg_ch
);

  localparam int NStg = 80;
  localparam int DivBase = 11;   // first divider stage index
  localparam int NDiv = 64;

  // calibration registers
  logic [15:0] t1_r;
  logic [31:0] t23_r, p12_r, p34_r, p56_r, p78_r;
  logic [15:0] p9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t23_r <= '0;
      p12_r <= '0;
      p34_r <= '0;
      p56_r <= '0;
      p78_r <= '0;
      p9_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        RegT1:   t1_r  <= cfg_ch.data[15:0];
        RegT2T3: t23_r <= cfg_ch.data;
        RegP1P2: p12_r <= cfg_ch.data;
        RegP3P4: p34_r <= cfg_ch.data;
        RegP5P6: p56_r <= cfg_ch.data;
        RegP7P8: p78_r <= cfg_ch.data;
        RegP9:   p9_r  <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  logic [31:0] t2_32, t3_32;
  assign t2_32 = {{16{t23_r[15]}}, t23_r[15:0]};
  assign t3_32 = {{16{t23_r[31]}}, t23_r[31:16]};

  // global advance: the whole pipe moves unless the output is stalled
  logic [NStg-1:0] vld_r;
  logic adv;
  assign adv = !vld_r[NStg-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NStg-2:0], in_ch.valid};
    end
  end

  // side payload carried along: raw pressure (front) and temperature
  logic [RawW-1:0] ap_r [8];
  logic [31:0]     tmp_r [NStg];

  // front stage registers
  logic [31:0] v1m_r, dd_r, v1_r, v2m_r, fine_r;
  logic [63:0] a_r, aalo_r, ap5_r, ap2m_r, aa_r, b6_r, a3_r, bsum_r, asum_r;
  logic [63:0] ap5_6_r, ap5_7_r, ap2m_6_r, ap2m_7_r;
  logic [31:0] aax_r;
  logic [63:0] a1m_r, num0_r, den_r, num_r;

  logic [31:0] x1, dt;
  logic [63:0] sq_fix;
  logic [63:0] pneg;
  assign x1 = {15'd0, in_ch.raw_temperature[19:3]} - {15'd0, t1_r, 1'b0};
  assign dt = {16'd0, in_ch.raw_temperature[19:4]} - {16'd0, t1_r};
  assign sq_fix = {aax_r[30:0], 33'd0};
  assign pneg = PresFull - {44'd0, ap_r[7]};

  always_ff @(posedge clk) begin
    if (adv) begin
      // S1: temperature products
      v1m_r    <= 32'(x1 * t2_32);
      dd_r     <= 32'(dt * dt);
      ap_r[0]  <= in_ch.raw_pressure;
      // S2
      v1_r     <= asr32(v1m_r, 11);
      v2m_r    <= 32'(asr32(dd_r, 12) * t3_32);
      // S3: fine temperature
      fine_r   <= v1_r + asr32(v2m_r, 14);
      // S4: temperature result and pressure offset
      tmp_r[3] <= asr32(fine_r + {fine_r[29:0], 2'b00} + TempRound, 8);
      a_r      <= {{32{fine_r[31]}}, fine_r} - FineOffset;
      // S5: split square of a, and linear terms
      aalo_r   <= 64'(a_r[31:0] * a_r[31:0]);
      aax_r    <= 32'(a_r[31:0] * a_r[63:32]);
      ap5_r    <= mulc(a_r, sx17(p56_r[15:0]));
      ap2m_r   <= mulc(a_r, sx17(p12_r[31:16]));
      // S6: complete a*a mod 2^64 (cross term counted twice)
      aa_r     <= aalo_r + sq_fix;
      ap5_6_r  <= ap5_r;
      ap2m_6_r <= ap2m_r;
      // S7
      b6_r     <= mulc(aa_r, sx17(p56_r[31:16]));
      a3_r     <= mulc(aa_r, sx17(p34_r[15:0]));
      ap5_7_r  <= ap5_6_r;
      ap2m_7_r <= ap2m_6_r;
      // S8
      bsum_r   <= b6_r + {ap5_7_r[46:0], 17'd0}
                  + {{13{p34_r[31]}}, p34_r[31:16], 35'd0};
      asum_r   <= asr64(a3_r, 8) + {ap2m_7_r[51:0], 12'd0};
      // S9
      a1m_r    <= mulc(P1Bias + asum_r, {1'b0, p12_r[15:0]});
      num0_r   <= {pneg[32:0], 31'd0} - bsum_r;
      // S10
      den_r    <= asr64(a1m_r, 33);
      num_r    <= 64'(num0_r * PresScale);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i < 8; i++) ap_r[i] <= ap_r[i-1];
      for (int i = 4; i < NStg; i++) tmp_r[i] <= tmp_r[i-1];
    end
  end

  // S11: divider operand prep (magnitudes, result sign, zero divisor)
  logic [63:0] pan_r, pad_r;
  logic        psg_r, pz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pan_r <= num_r[63] ? (64'd0 - num_r) : num_r;
      pad_r <= den_r[63] ? (64'd0 - den_r) : den_r;
      psg_r <= num_r[63] ^ den_r[63];
      pz_r  <= (den_r == 64'd0);
    end
  end

  // divider array: one quotient bit per stage; dn shifts out the dividend
  // and shifts in quotient bits
  logic [63:0] drem_r [NDiv];
  logic [63:0] dn_r   [NDiv];
  logic [63:0] dd_d_r [NDiv];
  logic        dsg_r  [NDiv];
  logic        dz_r   [NDiv];

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    logic [63:0] rem_in, n_in, d_in;
    logic        sg_in, z_in;
    logic [64:0] trial, diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign n_in   = pan_r;
      assign d_in   = pad_r;
      assign sg_in  = psg_r;
      assign z_in   = pz_r;
    end else begin : g_next
      assign rem_in = drem_r[k-1];
      assign n_in   = dn_r[k-1];
      assign d_in   = dd_d_r[k-1];
      assign sg_in  = dsg_r[k-1];
      assign z_in   = dz_r[k-1];
    end
    assign trial = {rem_in, n_in[63]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = !diff[64];
    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[k] <= ge ? diff[63:0] : trial[63:0];
        dn_r[k]   <= {n_in[62:0], ge};
        dd_d_r[k] <= d_in;
        dsg_r[k]  <= sg_in;
        dz_r[k]   <= z_in;
      end
    end
  end

  // back stages
  logic [63:0] q_r, q2_r, xlo_r, f_r, xx_r, f3_r, q3_r, e_r, f4_r, q4_r;
  logic [31:0] xx_x_r;
  logic        z1_r, z2_r, z3_r, z4_r;
  logic [63:0] xq, pfin;
  logic [63:0] xx_fix;
  assign xq     = asr64(q_r, 13);
  assign xx_fix = {xx_x_r[30:0], 33'd0};
  assign pfin   = asr64(q4_r + e_r + f4_r, 8) + {{44{p78_r[15]}}, p78_r[15:0], 4'd0};

  logic [31:0] pres_r;
  logic        inv_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Q1: signed quotient, truncated toward zero
      q_r    <= dsg_r[NDiv-1] ? (64'd0 - dn_r[NDiv-1]) : dn_r[NDiv-1];
      z1_r   <= dz_r[NDiv-1];
      // Q2: split square of q>>13, and the p8 term
      xlo_r  <= 64'(xq[31:0] * xq[31:0]);
      xx_x_r <= 32'(xq[31:0] * xq[63:32]);
      f_r    <= asr64(mulc(q_r, sx17(p78_r[31:16])), 19);
      q2_r   <= q_r;
      z2_r   <= z1_r;
      // Q3
      xx_r   <= xlo_r + xx_fix;
      f3_r   <= f_r;
      q3_r   <= q2_r;
      z3_r   <= z2_r;
      // Q4: p9 term
      e_r    <= asr64(mulc(xx_r, sx17(p9_r)), 25);
      f4_r   <= f3_r;
      q4_r   <= q3_r;
      z4_r   <= z3_r;
      // Q5: output register
      pres_r <= z4_r ? 32'd0 : pfin[31:0];
      inv_r  <= z4_r;
    end
  end

  assign out_ch.valid             = vld_r[NStg-1];
  assign out_ch.temperature_centi = tmp_r[NStg-1];
  assign out_ch.pressure_q24_8    = pres_r;
  assign out_ch.pressure_invalid  = inv_r;

  `BPC_ASSERT(a_inv_zero, out_ch.valid && out_ch.pressure_invalid |-> out_ch.pressure_q24_8 == 32'd0, "invalid beat carries nonzero pressure")
  `BPC_ASSERT(a_hold, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(pres_r) && $stable(inv_r), "stalled result changed")
  `BPC_ASSERT_ALWAYS(a_rst, $past(!rst_n) |-> !out_ch.valid, "result valid right after reset")

endmodule
